FILE: src/sitda_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package sitda_pkg;

   localparam int NUM_W         = 32;
   localparam int NUM_DIGITS    = 10;
   localparam int DIGIT_W       = 4;
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int BITS_PER_STEP = 4;
   localparam int NUM_STEPS     = NUM_W / BITS_PER_STEP;
   localparam int STEP_CNT_W    = $clog2(NUM_STEPS);
   localparam int IDX_W         = $clog2(NUM_DIGITS);

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FIND,
      ST_SIGN,
      ST_DIGITS
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic step;
      logic find;
      logic emit_sign;
      logic emit_digit;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic conv_done;
      logic neg;
      logic digits_done;
   } status_type;

endpackage

FILE: src/sitda_dp.sv
// Datapath: magnitude capture, binary-to-BCD conversion four bits a cycle,
// digit selection and the registered result beat. Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_dp import sitda_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic [NUM_W-1:0]  req_number,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_character,
   output logic              rsp_last
);

   logic [NUM_W-1:0]      mag_ff, mag_in;
   logic [BCD_W-1:0]      bcd_ff, bcd_in;
   logic                  neg_ff, neg_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  strobe_ff, strobe_in;
   logic [7:0]            char_ff, char_in;
   logic                  last_ff, last_in;
   logic [DIGIT_W-1:0]    cur_digit;

   // shift-add-3 over BITS_PER_STEP bits of the magnitude
   function automatic logic [BCD_W+NUM_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                                      input logic [NUM_W-1:0] mag);
      logic [BCD_W+NUM_W-1:0] acc;
      acc = {bcd, mag};
      for (int b = 0; b < BITS_PER_STEP; b++) begin
         for (int d = 0; d < NUM_DIGITS; d++) begin
            if (acc[NUM_W + d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
               acc[NUM_W + d*DIGIT_W +: DIGIT_W] =
                  acc[NUM_W + d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
         end
         acc = acc << 1;
      end
      return acc;
   endfunction

   // index of the most significant nonzero digit, zero when all are zero
   function automatic logic [IDX_W-1:0] top_digit(input logic [BCD_W-1:0] bcd);
      logic [IDX_W-1:0] pos;
      pos = '0;
      for (int d = 0; d < NUM_DIGITS; d++) begin
         if (bcd[d*DIGIT_W +: DIGIT_W] != '0) begin
            pos = IDX_W'(d);
         end
      end
      return pos;
   endfunction

   assign cur_digit = bcd_ff[idx_ff*DIGIT_W +: DIGIT_W];

   always_comb begin
      mag_in    = mag_ff;
      bcd_in    = bcd_ff;
      neg_in    = neg_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = last_ff;
      if (cmd.load) begin
         neg_in = req_number[NUM_W-1];
         // 0 - raw also gives the right magnitude for the most negative value
         mag_in = req_number[NUM_W-1] ? (NUM_W'(0) - req_number) : req_number;
         bcd_in = '0;
         cnt_in = '0;
      end
      if (cmd.step) begin
         {bcd_in, mag_in} = dabble(bcd_ff, mag_ff);
         cnt_in = cnt_ff + STEP_CNT_W'(1);
      end
      if (cmd.find) begin
         idx_in = top_digit(bcd_ff);
      end
      if (cmd.emit_sign) begin
         strobe_in = 1'b1;
         char_in   = CHAR_MINUS;
         last_in   = 1'b0;
      end
      if (cmd.emit_digit) begin
         strobe_in = 1'b1;
         char_in   = CHAR_ZERO + {4'b0, cur_digit};
         last_in   = (idx_ff == '0);
         idx_in    = idx_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      mag_ff  <= mag_in;
      bcd_ff  <= bcd_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign status.conv_done   = (cnt_ff == STEP_CNT_W'(NUM_STEPS - 1));
   assign status.neg         = neg_ff;
   assign status.digits_done = (idx_ff == '0);

   assign rsp_strobe    = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last      = last_ff;

endmodule

FILE: src/sitda_ctrl.sv
// Controller: sequences capture, conversion, digit search and character beats.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_ctrl import sitda_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            cmd.step = 1'b1;
            if (status.conv_done) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            cmd.find = 1'b1;
            state_in = status.neg ? ST_SIGN : ST_DIGITS;
         end
         ST_SIGN: begin
            cmd.emit_sign = 1'b1;
            state_in      = ST_DIGITS;
         end
         ST_DIGITS: begin
            cmd.emit_digit = 1'b1;
            if (status.digits_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

FILE: src/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal text converter.
// Depends on sitda_pkg, sitda_ctrl and sitda_dp.
`timescale 1ns / 1ps
//
// Usage:
//   Input: drive req_number and raise start; the number is taken at the clock
//   edge where start is high and busy is low. busy stays high until the last
//   character has been issued.
//   Output: each character is one beat on rsp_character with rsp_strobe high
//   for exactly one cycle; rsp_last marks the final character. A negative
//   number starts with '-', zero gives a single '0', no leading zeros.
//   Sequence: after the accepting edge the binary-to-BCD unit converts the
//   magnitude (4 bits per cycle), the leading digit is then located, and one
//   beat per character (1 to 11) follows on consecutive cycles, whether the
//   first is the sign or a digit. A new number is not taken until the block
//   has issued every character of the one before.
//   The receiver cannot stall; beats are never held.
//   Reset (synchronous, active high) returns the controller to idle and
//   drops rsp_strobe; a number in progress is abandoned.

module signed_int_to_decimal_ascii import sitda_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [NUM_W-1:0]  req_number,
   output logic              rsp_strobe,
   output logic [7:0]        rsp_character,
   output logic              rsp_last
);

   cmd_type    cmd;
   status_type status;

   sitda_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   sitda_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_number    (req_number),
      .cmd           (cmd),
      .status        (status),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

FILE: src/sitda_checker.sv
// Port-level checks for signed_int_to_decimal_ascii, attached by bind.
// Depends on sitda_pkg.
`timescale 1ns / 1ps

module sitda_checker import sitda_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input logic [7:0]       rsp_character,
   input logic             rsp_last
);

   // an accepted number keeps the block busy on the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // characters of one number come on consecutive cycles
   a_beats_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> rsp_strobe)
      else $error("gap inside a character sequence");

   // a sign beat is never the last one
   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_character == CHAR_MINUS) |-> !rsp_last)
      else $error("minus sign marked last");

   // only '-' or a decimal digit leaves the block
   a_char_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((rsp_character == CHAR_MINUS) ||
                      (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_NINE)))
      else $error("illegal character code");

   // no beat in the cycle after a number is taken
   a_accept_quiet: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("beat right after accept");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (.*);
